FILE: hw/rtl/bitmap_line_fill_engine_core_defines.svh
// Assertion macros shared by the bitmap line fill engine RTL.
`ifndef BITMAP_LINE_FILL_ENGINE_CORE_DEFINES_SVH
`define BITMAP_LINE_FILL_ENGINE_CORE_DEFINES_SVH

// Checked at every clock edge outside reset.
`define BLFE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define BLFE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/blfe_pkg.sv
// Package with types, command codes and constants of the bitmap line fill engine.
package blfe_pkg;

  localparam int WORD_BITS          = 32;
  localparam int WIDTH_PIXELS_DEF   = 640;
  localparam int HEIGHT_LINES_DEF   = 480;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [31:0] MSB_ONE   = 32'h8000_0000;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_HSPAN = 2'd1;
  localparam logic [1:0] OP_VLINE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CLEAR,
    ST_DRAW,
    ST_READ,
    ST_RDATA,
    ST_FINISH
  } state_t;

  // Request to the mask unit for one word of a command.
  typedef struct packed {
    logic       vert;
    logic [4:0] word_idx;
    logic [9:0] x_start;
    logic [9:0] x_end;
  } mask_req_t;

endpackage

FILE: hw/rtl/blfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module blfe_ram import blfe_pkg::*; #(
  parameter int DATA_W = WORD_BITS,
  parameter int DEPTH  = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/blfe_mask.sv
// Shift unit that builds the OR mask for one word of a span or a vertical line.
module blfe_mask import blfe_pkg::*; (
  input  mask_req_t   req,
  output logic [31:0] mask
);

  logic [4:0]  lo;
  logic [5:0]  hi;
  logic [31:0] head;
  logic [31:0] tail;

  always_comb begin
    // The first word starts at x_start, the word holding x_end stops there.
    lo   = (req.word_idx == req.x_start[9:5]) ? req.x_start[4:0] : 5'd0;
    hi   = (req.word_idx == req.x_end[9:5]) ? {1'b0, req.x_end[4:0]} : 6'd32;
    head = ALL_ONES >> lo;
    tail = hi[5] ? 32'd0 : (ALL_ONES >> hi[4:0]);
    if (req.vert) begin
      mask = MSB_ONE >> req.x_start[4:0];
    end else begin
      mask = head & ~tail;
    end
  end

endmodule

FILE: hw/rtl/bitmap_line_fill_engine_core.sv
// Sequence per command: accept in idle, set up, then clear, draw or read, one store word per cycle;
// a read passes through a read-data state, and an out-of-range command goes straight from setup to
// finish. Span and vertical line draws overlap each read with the previous write-back.
// One command at a time; a result waits in finish while the output register is full and not taken.
// The next command is taken while a result waits; reset clears the sequencer and output valid.
module bitmap_line_fill_engine_core import blfe_pkg::*; #(
  parameter int WIDTH_PIXELS = WIDTH_PIXELS_DEF,
  parameter int HEIGHT_LINES = HEIGHT_LINES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [9:0]  in_x_start,
  input  logic [9:0]  in_x_end,
  input  logic [8:0]  in_y_start,
  input  logic [8:0]  in_y_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_word,
  output logic        out_range_error
);

`include "bitmap_line_fill_engine_core_defines.svh"

  localparam int WORDS_PER_ROW = (WIDTH_PIXELS + 31) / 32;
  localparam int DEPTH         = HEIGHT_LINES * WORDS_PER_ROW;
  localparam int AW            = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW            = $clog2(DEPTH + 1);
  localparam logic [12:0] W_LIM = 13'(WIDTH_PIXELS);
  localparam logic [12:0] H_LIM = 13'(HEIGHT_LINES);
  localparam logic [AW-1:0] WPR_A = AW'(WORDS_PER_ROW);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  state_t state_r, state_nxt;

  logic [1:0]  op_r;
  logic [9:0]  xs_r, xe_r;
  logic [8:0]  ys_r, ye_r;
  logic [AW-1:0] addr_r;
  logic [CW-1:0] cnt_r;
  logic [4:0]  widx_r;
  logic        err_r;
  logic        pend_r;
  logic [AW-1:0] pend_addr_r;
  logic [31:0] pend_mask_r;
  logic [31:0] res_word_r;
  logic        out_valid_r;
  logic [31:0] out_read_word_r;
  logic        out_range_error_r;

  logic        err_calc;
  logic [AW-1:0] base_addr;
  logic [5:0]  hcnt;
  logic [8:0]  vcnt;
  logic [CW-1:0] cnt_init;
  logic        in_fire;
  logic        out_load;
  mask_req_t   mreq;
  logic [31:0] mask;

  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [31:0]   ram_wr_data;
  logic          ram_rd_en;
  logic [AW-1:0] ram_rd_addr;
  logic [31:0]   ram_rd_data;

  blfe_ram #(
    .DATA_W (WORD_BITS),
    .DEPTH  (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign mreq.vert     = (op_r == OP_VLINE);
  assign mreq.word_idx = widx_r;
  assign mreq.x_start  = xs_r;
  assign mreq.x_end    = xe_r;

  blfe_mask u_mask (
    .req  (mreq),
    .mask (mask)
  );

  assign in_fire  = in_valid && in_ready;
  assign out_load = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  // Range check and start values, evaluated from the captured command.
  always_comb begin
    case (op_r)
      OP_HSPAN: err_calc = ({3'd0, xs_r} >= W_LIM) || ({3'd0, xe_r} > W_LIM) ||
                           (xs_r > xe_r) || ({4'd0, ys_r} >= H_LIM);
      OP_VLINE: err_calc = ({3'd0, xs_r} >= W_LIM) || ({4'd0, ys_r} >= H_LIM) ||
                           ({4'd0, ye_r} > H_LIM) || (ys_r > ye_r);
      OP_READ:  err_calc = ({3'd0, xs_r} >= W_LIM) || ({4'd0, ys_r} >= H_LIM);
      default:  err_calc = 1'b0;
    endcase
    base_addr = AW'(ys_r) * WPR_A + AW'(xs_r[9:5]);
    hcnt = 6'(({1'b0, xe_r} + 11'd31) >> 5) - {1'b0, xs_r[9:5]};
    vcnt = ye_r - ys_r;
    case (op_r)
      OP_CLEAR: cnt_init = DEPTH_C;
      OP_HSPAN: cnt_init = CW'(hcnt);
      OP_VLINE: cnt_init = CW'(vcnt);
      default:  cnt_init = CW'(1);
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        if (err_calc) begin
          state_nxt = ST_FINISH;
        end else begin
          case (op_r)
            OP_CLEAR: state_nxt = ST_CLEAR;
            OP_READ:  state_nxt = ST_READ;
            default:  state_nxt = ST_DRAW;
          endcase
        end
      end
      ST_CLEAR: begin
        if (cnt_r == CW'(1)) state_nxt = ST_FINISH;
      end
      ST_DRAW: begin
        if ((cnt_r == '0) && !pend_r) state_nxt = ST_FINISH;
      end
      ST_READ:   state_nxt = ST_RDATA;
      ST_RDATA:  state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Memory port and handshake outputs.
  always_comb begin
    in_ready    = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = pend_addr_r;
    ram_wr_data = ram_rd_data | pend_mask_r;
    ram_rd_en   = 1'b0;
    ram_rd_addr = addr_r;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = addr_r;
        ram_wr_data = 32'd0;
      end
      ST_DRAW: begin
        // Read of the next word overlaps the write-back of the previous one.
        ram_rd_en = (cnt_r != '0);
        ram_wr_en = pend_r;
      end
      ST_READ: ram_rd_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_SETUP: err_r <= err_calc;
        ST_DRAW:  pend_r <= (cnt_r != '0);
        default:  pend_r <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_opcode;
      xs_r <= in_x_start;
      xe_r <= in_x_end;
      ys_r <= in_y_start;
      ye_r <= in_y_end;
    end
    case (state_r)
      ST_SETUP: begin
        addr_r     <= (op_r == OP_CLEAR) ? '0 : base_addr;
        cnt_r      <= cnt_init;
        widx_r     <= xs_r[9:5];
        res_word_r <= 32'd0;
      end
      ST_CLEAR: begin
        addr_r <= addr_r + AW'(1);
        cnt_r  <= cnt_r - CW'(1);
      end
      ST_DRAW: begin
        if (cnt_r != '0) begin
          addr_r      <= addr_r + ((op_r == OP_VLINE) ? WPR_A : AW'(1));
          cnt_r       <= cnt_r - CW'(1);
          widx_r      <= widx_r + 5'd1;
          pend_addr_r <= addr_r;
          pend_mask_r <= mask;
        end
      end
      ST_RDATA: res_word_r <= ram_rd_data;
      default: ;
    endcase
    if (out_load) begin
      out_read_word_r   <= res_word_r;
      out_range_error_r <= err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_word   = out_read_word_r;
  assign out_range_error = out_range_error_r;

  `BLFE_ASSERT_ALWAYS(a_pend_only_in_draw, pend_r |-> (state_r == ST_DRAW), "write-back pending outside draw")
  `BLFE_ASSERT(a_err_word_zero, (out_valid_r && out_range_error_r) |-> (out_read_word_r == 32'd0), "range error with nonzero word")
  `BLFE_ASSERT(a_clear_count, (state_r == ST_CLEAR) |-> (cnt_r != '0), "clear sweep count ran out")
  `BLFE_ASSERT(a_finish_loads, out_load |=> (out_valid_r && (state_r == ST_IDLE)), "finished command not presented")

endmodule
